// ===== hdl/vctq_pkg.sv =====
// shared types and constants for the virtual cpu timer queue
package vctq_pkg;

    localparam int TID_W       = 4;
    localparam int AMT_W       = 64;
    localparam int OP_W        = 3;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_ONESHOT = 3'd0,
        OP_ADD_PERIODIC = 3'd1,
        OP_MOD_ONESHOT = 3'd2,
        OP_MOD_PERIODIC = 3'd3,
        OP_DELETE = 3'd4,
        OP_FORWARD = 3'd5,
        OP_EXPIRE = 3'd6
    } vctq_op_t;

endpackage

// ===== hdl/virtual_cpu_timer_queue.sv =====
// virtual cpu timer queue: timer table against a shared elapsed base, one shared 64-bit adder
//
//   channel | dir | tdata                                  | tuser                        | tlast
//   s_*     | in  | [3:0] timer_id, [67:4] amount, pad     | [2:0] operation              | -
//   m_*     | out | [3:0] result_timer_id, pad             | [0] was_pending [1] due [2] fired | last
//
// steps: delete and echo emit at once; add sums, then compares next due if others pend;
//   modify compares first; forward sums then compares, or emits at once on an empty table;
//   expire runs rebase, select (per fired timer) and min passes, echoing if none fires;
//   each pass walks the expiry memory one entry per cycle through its single read port
// one 64-bit add/subtract unit serves every sum and compare in turn
// reset: no clearing pass, pending bits clear at once, base and next due go to zero
// stalls: one output register; while a result waits for m_tready the sequencer holds
//   at its next result, and a new item is taken only with the sequencer back at idle
module virtual_cpu_timer_queue #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vctq_pkg::S_TDATA_W-1:0] s_tdata,  // timer_id, amount, zero pad
    input  logic [vctq_pkg::OP_W-1:0]      s_tuser,  // operation
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vctq_pkg::M_TDATA_W-1:0] m_tdata,  // result_timer_id, zero pad
    output logic [vctq_pkg::M_TUSER_W-1:0] m_tuser,  // was_pending, due, fired
    output logic                           m_tlast
);

    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam logic [NUM_TIMERS-1:0] ONE_HOT0 = NUM_TIMERS'(1);
    localparam int TW = vctq_pkg::TID_W;
    localparam int AW = vctq_pkg::AMT_W;
    localparam int RW = vctq_pkg::RES_CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_CMP,
        ST_INS_ADD,
        ST_INS_CMP,
        ST_FWD_ADD,
        ST_FWD_CMP,
        ST_EXP_REBASE,
        ST_EXP_SELECT,
        ST_EXP_MIN,
        ST_EMIT
    } state_t;

    // timer stores, one write and one registered read per cycle each
    logic [AW-1:0] expiry_mem [NUM_TIMERS];
    logic [AW-1:0] reload_mem [NUM_TIMERS];
    logic [AW-1:0] rd_exp_reg;
    logic [AW-1:0] rd_rel_reg;

    state_t                 state_reg;
    state_t                 ret_state_reg;
    vctq_pkg::vctq_op_t     op_reg;
    logic [TW-1:0]          tid_reg;
    logic [AW-1:0]          amount_reg;
    logic [NUM_TIMERS-1:0]  pending_reg;
    logic [NUM_TIMERS-1:0]  fire_reg;
    logic [AW-1:0]          base_reg;
    logic [AW-1:0]          next_due_reg;
    logic [AW-1:0]          cmp_reg;      // running minimum or pending expiry
    logic                   any_reg;      // cmp_reg holds a candidate
    logic [IDX_W-1:0]       best_reg;
    logic [AW-1:0]          best_rel_reg;
    logic [CNT_W-1:0]       cnt_reg;      // scan read pointer
    logic                   p_vld_reg;    // scan entry in the read register
    logic [IDX_W-1:0]       p_idx_reg;
    logic [RW-1:0]          n_reg;        // fired results reported so far

    // staged result
    logic [TW-1:0]          res_id_reg;
    logic                   res_wp_reg;
    logic                   res_due_reg;
    logic                   res_fired_reg;
    logic                   res_last_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [TW-1:0]          m_id_reg;
    logic                   m_wp_reg;
    logic                   m_due_reg;
    logic                   m_fired_reg;
    logic                   m_last_reg;

    // shared adder
    logic [AW-1:0]          alu_a;
    logic [AW-1:0]          alu_b;
    logic                   alu_sub;
    logic [AW:0]            alu_sum;
    logic [AW-1:0]          alu_res;
    logic                   lt_u;
    logic                   lt_s;
    logic                   eq;

    // memory port controls
    logic [IDX_W-1:0]       rd_addr;
    logic                   exp_we;
    logic [IDX_W-1:0]       exp_waddr;
    logic [AW-1:0]          exp_wdata;
    logic                   rel_we;
    logic [IDX_W-1:0]       rel_waddr;
    logic [AW-1:0]          rel_wdata;

    logic [TW-1:0]          in_tid;
    logic [AW-1:0]          in_amount;
    vctq_pkg::vctq_op_t     in_op;
    logic                   in_range;
    logic                   accept;
    logic [IDX_W-1:0]       id_idx;
    logic [NUM_TIMERS-1:0]  id_mask;
    logic [NUM_TIMERS-1:0]  best_mask;
    logic                   others_pending;
    logic                   fire_left;
    logic                   scan_done;
    logic                   out_free;

    assign in_tid    = s_tdata[TW-1:0];
    assign in_amount = s_tdata[TW+AW-1:TW];
    assign in_op     = vctq_pkg::vctq_op_t'(s_tuser);
    assign in_range  = 32'(in_tid) < NUM_TIMERS;
    assign accept    = s_tvalid && s_tready;

    assign id_idx         = IDX_W'(tid_reg);
    assign id_mask        = ONE_HOT0 << id_idx;
    assign best_mask      = ONE_HOT0 << best_reg;
    assign others_pending = |(pending_reg & ~id_mask);
    assign fire_left      = |(fire_reg & ~best_mask);
    assign scan_done      = (cnt_reg == CNT_W'(NUM_TIMERS)) && !p_vld_reg;
    assign out_free       = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(vctq_pkg::M_TDATA_W - TW){1'b0}}, m_id_reg};
    assign m_tuser  = {m_fired_reg, m_due_reg, m_wp_reg};
    assign m_tlast  = m_last_reg;

    // a + b or a - b, carry out set when a >= b on subtract
    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
    assign alu_res = alu_sum[AW-1:0];
    assign lt_u    = !alu_sum[AW];
    assign lt_s    = alu_res[AW-1] ^
                     ((alu_a[AW-1] != alu_b[AW-1]) && (alu_res[AW-1] != alu_a[AW-1]));
    assign eq      = (alu_res == '0);

    // operand selection and memory port control per sequencer step
    always_comb
    begin
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b1;
        rd_addr   = cnt_reg[IDX_W-1:0];
        exp_we    = 1'b0;
        exp_waddr = id_idx;
        exp_wdata = alu_res;
        rel_we    = 1'b0;
        rel_waddr = id_idx;
        rel_wdata = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // fetch the stored expiry for a modify
                rd_addr   = IDX_W'(in_tid);
                rel_waddr = IDX_W'(in_tid);
                rel_wdata = (in_op == vctq_pkg::OP_ADD_PERIODIC) ? in_amount : '0;
                rel_we    = accept && in_range &&
                            (in_op == vctq_pkg::OP_ADD_ONESHOT ||
                             in_op == vctq_pkg::OP_ADD_PERIODIC);
            end
            ST_MOD_CMP:
            begin
                alu_a     = amount_reg;
                alu_b     = rd_exp_reg;
                rel_wdata = (op_reg == vctq_pkg::OP_MOD_PERIODIC) ? amount_reg : '0;
                rel_we    = !(pending_reg[id_idx] && eq);
            end
            ST_INS_ADD:
            begin
                alu_a     = amount_reg;
                alu_b     = base_reg;
                alu_sub   = 1'b0;
                exp_we    = 1'b1;
                exp_wdata = others_pending ? alu_res : amount_reg;
            end
            ST_INS_CMP:
            begin
                alu_a = cmp_reg;
                alu_b = next_due_reg;
            end
            ST_FWD_ADD:
            begin
                alu_a   = base_reg;
                alu_b   = amount_reg;
                alu_sub = 1'b0;
            end
            ST_FWD_CMP:
            begin
                alu_a = base_reg;
                alu_b = next_due_reg;
            end
            ST_EXP_REBASE:
            begin
                // survivors are rebased in place
                alu_a     = rd_exp_reg;
                alu_b     = base_reg;
                exp_waddr = p_idx_reg;
                exp_we    = p_vld_reg && pending_reg[p_idx_reg] && !lt_u;
            end
            ST_EXP_SELECT:
            begin
                alu_a     = rd_exp_reg;
                alu_b     = cmp_reg;
                // recharge the chosen periodic timer
                exp_waddr = best_reg;
                exp_wdata = best_rel_reg;
                exp_we    = scan_done && (best_rel_reg != '0);
            end
            ST_EXP_MIN:
            begin
                alu_a = rd_exp_reg;
                alu_b = cmp_reg;
            end
            ST_EMIT:
            begin
                alu_a = '0;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            expiry_mem[exp_waddr] <= exp_wdata;
        end
        if (rel_we)
        begin
            reload_mem[rel_waddr] <= rel_wdata;
        end
        rd_exp_reg <= expiry_mem[rd_addr];
        rd_rel_reg <= reload_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_state_reg <= ST_IDLE;
            op_reg        <= vctq_pkg::OP_ADD_ONESHOT;
            tid_reg       <= '0;
            amount_reg    <= '0;
            pending_reg   <= '0;
            fire_reg      <= '0;
            base_reg      <= '0;
            next_due_reg  <= '0;
            cmp_reg       <= '0;
            any_reg       <= 1'b0;
            best_reg      <= '0;
            best_rel_reg  <= '0;
            cnt_reg       <= '0;
            p_vld_reg     <= 1'b0;
            p_idx_reg     <= '0;
            n_reg         <= '0;
            res_id_reg    <= '0;
            res_wp_reg    <= 1'b0;
            res_due_reg   <= 1'b0;
            res_fired_reg <= 1'b0;
            res_last_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_id_reg      <= '0;
            m_wp_reg      <= 1'b0;
            m_due_reg     <= 1'b0;
            m_fired_reg   <= 1'b0;
            m_last_reg    <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // scan pointer runs in the three expire passes
            p_vld_reg <= 1'b0;
            if (state_reg == ST_EXP_REBASE || state_reg == ST_EXP_SELECT ||
                state_reg == ST_EXP_MIN)
            begin
                p_vld_reg <= (cnt_reg != CNT_W'(NUM_TIMERS));
                p_idx_reg <= cnt_reg[IDX_W-1:0];
                if (cnt_reg != CNT_W'(NUM_TIMERS))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg        <= in_op;
                        tid_reg       <= in_tid;
                        amount_reg    <= in_amount;
                        res_id_reg    <= in_tid;
                        res_wp_reg    <= 1'b0;
                        res_due_reg   <= 1'b0;
                        res_fired_reg <= 1'b0;
                        res_last_reg  <= 1'b1;
                        ret_state_reg <= ST_IDLE;
                        cnt_reg       <= '0;
                        any_reg       <= 1'b0;
                        n_reg         <= '0;
                        state_reg     <= ST_EMIT;
                        unique case (in_op) inside
                            vctq_pkg::OP_EXPIRE:
                            begin
                                state_reg <= ST_EXP_REBASE;
                            end
                            vctq_pkg::OP_FORWARD:
                            begin
                                if (|pending_reg)
                                begin
                                    state_reg <= ST_FWD_ADD;
                                end
                            end
                            vctq_pkg::OP_ADD_ONESHOT, vctq_pkg::OP_ADD_PERIODIC:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= ST_INS_ADD;
                                end
                            end
                            vctq_pkg::OP_MOD_ONESHOT, vctq_pkg::OP_MOD_PERIODIC:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= ST_MOD_CMP;
                                end
                            end
                            vctq_pkg::OP_DELETE:
                            begin
                                if (in_range)
                                begin
                                    res_wp_reg                        <= pending_reg[IDX_W'(in_tid)];
                                    pending_reg[IDX_W'(in_tid)]       <= 1'b0;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end

                ST_MOD_CMP:
                begin
                    res_wp_reg <= pending_reg[id_idx];
                    if (pending_reg[id_idx] && eq)
                    begin
                        // same expiry, nothing to do
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        pending_reg[id_idx] <= 1'b0;
                        state_reg           <= ST_INS_ADD;
                    end
                end

                ST_INS_ADD:
                begin
                    pending_reg[id_idx] <= 1'b1;
                    if (others_pending)
                    begin
                        cmp_reg   <= alu_res;
                        state_reg <= ST_INS_CMP;
                    end
                    else
                    begin
                        // empty table restarts the base
                        next_due_reg <= amount_reg;
                        base_reg     <= '0;
                        state_reg    <= ST_EMIT;
                    end
                end

                ST_INS_CMP:
                begin
                    if (lt_s)
                    begin
                        next_due_reg <= cmp_reg;
                    end
                    state_reg <= ST_EMIT;
                end

                ST_FWD_ADD:
                begin
                    base_reg  <= alu_res;
                    state_reg <= ST_FWD_CMP;
                end

                ST_FWD_CMP:
                begin
                    res_due_reg <= !lt_u;
                    state_reg   <= ST_EMIT;
                end

                ST_EXP_REBASE:
                begin
                    if (p_vld_reg && pending_reg[p_idx_reg] && lt_u)
                    begin
                        fire_reg[p_idx_reg]    <= 1'b1;
                        pending_reg[p_idx_reg] <= 1'b0;
                    end
                    if (scan_done)
                    begin
                        base_reg  <= '0;
                        cnt_reg   <= '0;
                        any_reg   <= 1'b0;
                        state_reg <= (|fire_reg) ? ST_EXP_SELECT : ST_EXP_MIN;
                    end
                end

                ST_EXP_SELECT:
                begin
                    // strict compare in index order keeps the lower index on ties
                    if (p_vld_reg && fire_reg[p_idx_reg] && (!any_reg || lt_u))
                    begin
                        cmp_reg      <= rd_exp_reg;
                        best_reg     <= p_idx_reg;
                        best_rel_reg <= rd_rel_reg;
                        any_reg      <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        fire_reg[best_reg] <= 1'b0;
                        if (best_rel_reg != '0)
                        begin
                            pending_reg[best_reg] <= 1'b1;
                        end
                        cnt_reg   <= '0;
                        any_reg   <= 1'b0;
                        state_reg <= fire_left ? ST_EXP_SELECT : ST_EXP_MIN;
                        if (n_reg < RW'(vctq_pkg::MAX_RESULTS))
                        begin
                            res_id_reg    <= TW'(best_reg);
                            res_fired_reg <= 1'b1;
                            res_last_reg  <= !fire_left ||
                                             (n_reg == RW'(vctq_pkg::MAX_RESULTS - 1));
                            n_reg         <= n_reg + 1'b1;
                            ret_state_reg <= fire_left ? ST_EXP_SELECT : ST_EXP_MIN;
                            state_reg     <= ST_EMIT;
                        end
                    end
                end

                ST_EXP_MIN:
                begin
                    if (p_vld_reg && pending_reg[p_idx_reg] && (!any_reg || lt_u))
                    begin
                        cmp_reg <= rd_exp_reg;
                        any_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        if (any_reg)
                        begin
                            next_due_reg <= cmp_reg;
                        end
                        ret_state_reg <= ST_IDLE;
                        // nothing fired: one echo result
                        state_reg     <= (n_reg == '0) ? ST_EMIT : ST_IDLE;
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_id_reg     <= res_id_reg;
                        m_wp_reg     <= res_wp_reg;
                        m_due_reg    <= res_due_reg;
                        m_fired_reg  <= res_fired_reg;
                        m_last_reg   <= res_last_reg;
                        state_reg    <= ret_state_reg;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sim/virtual_cpu_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the virtual cpu timer queue: directed and random timer traffic
module virtual_cpu_timer_queue_tb;

    localparam int NUM_TIMERS   = 16;
    localparam int CLK_HALF     = 4;
    // cycles the block may still be busy after its last report (expire rescans the table)
    localparam int SETTLE_CYCLES = 2 * (NUM_TIMERS + 1) + 16;
    // cycles without any transfer before the run is declared hung
    localparam int HANG_LIMIT   = 20000;
    localparam int IDLE_PERCENT = 16;
    // operation code with no meaning, answered by an echo
    localparam logic [vctq_pkg::OP_W-1:0] OP_UNUSED = '1;

    // one report as it leaves the block
    typedef struct packed {
        logic [vctq_pkg::TID_W-1:0] tid;
        logic                       was_pending;
        logic                       due;
        logic                       fired;
        logic                       last;
    } timer_report_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [vctq_pkg::S_TDATA_W-1:0] s_tdata = '0;   // timer_id, amount, zero pad
    logic [vctq_pkg::OP_W-1:0]      s_tuser = '0;   // operation
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [vctq_pkg::M_TDATA_W-1:0] m_tdata;        // result_timer_id, zero pad
    logic [vctq_pkg::M_TUSER_W-1:0] m_tuser;        // was_pending, due, fired
    logic                           m_tlast;

    virtual_cpu_timer_queue #(
        .NUM_TIMERS(NUM_TIMERS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #(CLK_HALF) clk = ~clk;

    // shadow copy of the timer table, kept in step with every accepted transfer
    logic [vctq_pkg::AMT_W-1:0] shadow_expiry [NUM_TIMERS];
    logic [vctq_pkg::AMT_W-1:0] shadow_reload [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]      shadow_pending = '0;
    logic [vctq_pkg::AMT_W-1:0] shadow_base = '0;
    logic [vctq_pkg::AMT_W-1:0] shadow_next_due = '0;

    timer_report_t timer_reports_q[$];
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    bit            steady = 1'b0;     // suppresses random idling on both sides

    // ------------------------------------------------------------------
    // timer table prediction
    // ------------------------------------------------------------------

    // arm a timer; an empty table restarts the base, otherwise the expiry is
    // rebased and next due follows a signed compare
    task automatic arm_timer(input int id, input logic [vctq_pkg::AMT_W-1:0] amt);
        logic [vctq_pkg::AMT_W-1:0] abs_expiry;
        if (shadow_pending == '0)
        begin
            shadow_next_due = amt;
            shadow_base     = '0;
            shadow_expiry[id] = amt;
        end
        else
        begin
            abs_expiry = amt + shadow_base;
            shadow_expiry[id] = abs_expiry;
            if ($signed(abs_expiry) < $signed(shadow_next_due))
                shadow_next_due = abs_expiry;
        end
        shadow_pending[id] = 1'b1;
    endtask

    // fire every timer below the base in expiry order (ties to lower index),
    // rebase the survivors, recharge periodic ones, then recompute next due
    task automatic expire_timers(input logic [vctq_pkg::TID_W-1:0] echo_tid);
        logic [NUM_TIMERS-1:0]      firing;
        logic [vctq_pkg::AMT_W-1:0] cutoff;
        logic [vctq_pkg::AMT_W-1:0] min_expiry;
        logic [vctq_pkg::TID_W-1:0] fired_ids [vctq_pkg::MAX_RESULTS];
        int                         n_fired;
        int                         best;
        bit                         found;
        timer_report_t              rpt;
        firing  = '0;
        cutoff  = shadow_base;
        n_fired = 0;
        found   = 1'b0;
        min_expiry = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (shadow_pending[i])
            begin
                if (shadow_expiry[i] < cutoff)
                begin
                    firing[i] = 1'b1;
                    shadow_pending[i] = 1'b0;
                end
                else
                    shadow_expiry[i] = shadow_expiry[i] - cutoff;
            end
        end
        shadow_base = '0;
        while (firing != '0)
        begin
            best = -1;
            for (int i = 0; i < NUM_TIMERS; i++)
                if (firing[i] && (best < 0 || shadow_expiry[i] < shadow_expiry[best]))
                    best = i;
            firing[best] = 1'b0;
            if (n_fired < vctq_pkg::MAX_RESULTS)
            begin
                fired_ids[n_fired] = best[vctq_pkg::TID_W-1:0];
                n_fired++;
            end
            if (shadow_reload[best] != '0)
            begin
                shadow_expiry[best]  = shadow_reload[best];
                shadow_pending[best] = 1'b1;
            end
        end
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (shadow_pending[i] && (!found || shadow_expiry[i] < min_expiry))
            begin
                min_expiry = shadow_expiry[i];
                found = 1'b1;
            end
        end
        if (found)
            shadow_next_due = min_expiry;
        if (n_fired == 0)
        begin
            rpt = '{tid: echo_tid, was_pending: 1'b0, due: 1'b0, fired: 1'b0, last: 1'b1};
            timer_reports_q.push_back(rpt);
        end
        for (int k = 0; k < n_fired; k++)
        begin
            rpt = '{tid: fired_ids[k], was_pending: 1'b0, due: 1'b0, fired: 1'b1,
                    last: (k == n_fired - 1)};
            timer_reports_q.push_back(rpt);
        end
    endtask

    // update the shadow table for one accepted operation and queue its reports
    task automatic apply_timer_op(input logic [vctq_pkg::OP_W-1:0] op,
                                  input logic [vctq_pkg::TID_W-1:0] tid,
                                  input logic [vctq_pkg::AMT_W-1:0] amt);
        logic          pend_flag;
        logic          due_flag;
        timer_report_t rpt;
        pend_flag = 1'b0;
        due_flag  = 1'b0;
        if (op == vctq_pkg::OP_EXPIRE)
        begin
            expire_timers(tid);
            return;
        end
        case (op) inside
            vctq_pkg::OP_ADD_ONESHOT, vctq_pkg::OP_ADD_PERIODIC:
            begin
                shadow_pending[tid] = 1'b0;
                shadow_reload[tid]  = (op == vctq_pkg::OP_ADD_PERIODIC) ? amt : '0;
                arm_timer(tid, amt);
            end
            vctq_pkg::OP_MOD_ONESHOT, vctq_pkg::OP_MOD_PERIODIC:
            begin
                pend_flag = shadow_pending[tid];
                // an unchanged pending timer is left alone
                if (!(shadow_pending[tid] && shadow_expiry[tid] == amt))
                begin
                    shadow_pending[tid] = 1'b0;
                    shadow_reload[tid]  = (op == vctq_pkg::OP_MOD_PERIODIC) ? amt : '0;
                    arm_timer(tid, amt);
                end
            end
            vctq_pkg::OP_DELETE:
            begin
                pend_flag = shadow_pending[tid];
                shadow_pending[tid] = 1'b0;
            end
            vctq_pkg::OP_FORWARD:
            begin
                if (shadow_pending != '0)
                begin
                    shadow_base = shadow_base + amt;
                    due_flag = (shadow_base >= shadow_next_due);
                end
            end
            default: ;  // unknown code: echo only
        endcase
        rpt = '{tid: tid, was_pending: pend_flag, due: due_flag, fired: 1'b0, last: 1'b1};
        timer_reports_q.push_back(rpt);
    endtask

    // ------------------------------------------------------------------
    // driving side
    // ------------------------------------------------------------------

    // one input transfer; valid stays up into the next item unless an idle gap is drawn
    task automatic send_timer_op(input logic [vctq_pkg::OP_W-1:0] op,
                                 input logic [vctq_pkg::TID_W-1:0] tid,
                                 input logic [vctq_pkg::AMT_W-1:0] amt);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, amt, tid};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        apply_timer_op(op, tid, amt);
    endtask

    // hold off the sender until every pending report is back and the block has settled
    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        while (timer_reports_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // amounts are mostly small so that timers actually fire; some span all 64 bits
    function automatic logic [vctq_pkg::AMT_W-1:0] random_amount();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return vctq_pkg::AMT_W'($urandom_range(300));
        else if (sel < 82)
            return vctq_pkg::AMT_W'($urandom_range(5000));
        else if (sel < 94)
            return {$urandom, $urandom};
        else
            return ~vctq_pkg::AMT_W'($urandom_range(3));
    endfunction

    task automatic random_timer_op();
        int                         sel;
        logic [vctq_pkg::OP_W-1:0]  op;
        logic [vctq_pkg::TID_W-1:0] tid;
        logic [vctq_pkg::AMT_W-1:0] amt;
        sel = $urandom_range(99);
        tid = vctq_pkg::TID_W'($urandom_range(NUM_TIMERS - 1));
        if (sel < 30)
            op = $urandom_range(1) ? vctq_pkg::OP_ADD_PERIODIC : vctq_pkg::OP_ADD_ONESHOT;
        else if (sel < 44)
            op = $urandom_range(1) ? vctq_pkg::OP_MOD_PERIODIC : vctq_pkg::OP_MOD_ONESHOT;
        else if (sel < 54)
            op = vctq_pkg::OP_DELETE;
        else if (sel < 78)
            op = vctq_pkg::OP_FORWARD;
        else if (sel < 98)
            op = vctq_pkg::OP_EXPIRE;
        else
            op = OP_UNUSED;
        amt = random_amount();
        // modify with the stored expiry now and then to hit the no-change path
        if ((op == vctq_pkg::OP_MOD_ONESHOT || op == vctq_pkg::OP_MOD_PERIODIC) &&
            shadow_pending[tid] && $urandom_range(2) == 0)
            amt = shadow_expiry[tid];
        send_timer_op(op, tid, amt);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty table cases, extremes of the fields, re-add, unchanged modify, wrap
    task automatic test_table_ops();
        send_timer_op(vctq_pkg::OP_EXPIRE, 4'd5, '0);            // expire with nothing pending
        send_timer_op(vctq_pkg::OP_FORWARD, 4'd3, 64'd77);       // forward on empty table
        send_timer_op(vctq_pkg::OP_DELETE, 4'd8, '0);            // delete of an idle timer
        send_timer_op(vctq_pkg::OP_ADD_ONESHOT, 4'd0, '0);
        send_timer_op(vctq_pkg::OP_ADD_PERIODIC, 4'd15, '1);     // largest, negative as signed
        send_timer_op(vctq_pkg::OP_ADD_PERIODIC, 4'd7, '0);      // zero interval is one-shot
        send_timer_op(vctq_pkg::OP_MOD_ONESHOT, 4'd0, '0);       // same expiry, no change
        send_timer_op(vctq_pkg::OP_MOD_PERIODIC, 4'd3, 64'd1000);
        send_timer_op(vctq_pkg::OP_ADD_PERIODIC, 4'd7, 64'd5);   // re-add while pending
        send_timer_op(vctq_pkg::OP_FORWARD, 4'd1, '1);           // base to all ones, the next forward wraps it
        send_timer_op(vctq_pkg::OP_FORWARD, 4'd2, 64'd10);
        send_timer_op(vctq_pkg::OP_EXPIRE, 4'd6, '0);
        send_timer_op(vctq_pkg::OP_DELETE, 4'd15, '0);
        send_timer_op(vctq_pkg::OP_DELETE, 4'd15, '0);
        send_timer_op(OP_UNUSED, 4'd9, 64'hA5A5_5A5A_F0F0_0F0F);
    endtask

    // equal expiries fire by index, periodic timers come back after expire
    task automatic test_expire_order();
        send_timer_op(vctq_pkg::OP_ADD_ONESHOT, 4'd9, 64'd20);
        send_timer_op(vctq_pkg::OP_ADD_PERIODIC, 4'd4, 64'd20);
        send_timer_op(vctq_pkg::OP_ADD_ONESHOT, 4'd2, 64'd20);
        send_timer_op(vctq_pkg::OP_ADD_PERIODIC, 4'd12, 64'd3);
        send_timer_op(vctq_pkg::OP_FORWARD, 4'd0, 64'd30);
        send_timer_op(vctq_pkg::OP_EXPIRE, 4'd0, '0);
        send_timer_op(vctq_pkg::OP_FORWARD, 4'd0, 64'd25);
        send_timer_op(vctq_pkg::OP_EXPIRE, 4'd0, '0);
        send_timer_op(vctq_pkg::OP_DELETE, 4'd4, '0);
        send_timer_op(vctq_pkg::OP_DELETE, 4'd12, '0);
    endtask

    task automatic test_random_traffic(input int n_items);
        repeat (n_items) random_timer_op();
    endtask

    // random traffic with the sender never idling and the receiver always ready
    task automatic test_back_to_back(input int n_items);
        steady = 1'b1;
        repeat (n_items) random_timer_op();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result checking, output stalls and hang counter
    // ------------------------------------------------------------------

    function automatic void check_field(input string name,
                                        input logic [vctq_pkg::TID_W-1:0] expected,
                                        input logic [vctq_pkg::TID_W-1:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     expected, actual);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        timer_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (timer_reports_q.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, actual tid %0d flags %b last %b",
                         $time, m_tdata[vctq_pkg::TID_W-1:0], m_tuser, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = timer_reports_q.pop_front();
                check_field("result_timer_id", want.tid, m_tdata[vctq_pkg::TID_W-1:0]);
                check_field("was_pending", vctq_pkg::TID_W'(want.was_pending),
                            vctq_pkg::TID_W'(m_tuser[0]));
                check_field("due", vctq_pkg::TID_W'(want.due), vctq_pkg::TID_W'(m_tuser[1]));
                check_field("fired", vctq_pkg::TID_W'(want.fired),
                            vctq_pkg::TID_W'(m_tuser[2]));
                check_field("last", vctq_pkg::TID_W'(want.last), vctq_pkg::TID_W'(m_tlast));
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    initial
    begin
        while (quiet_cycles < HANG_LIMIT)
            @(posedge clk);
        $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_ops();
        test_expire_order();
        wait_for_reports();
        test_random_traffic(55);
        test_back_to_back(50);
        wait_for_reports();
        test_random_traffic(40);
        wait_for_reports();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/vctq_pkg.sv
hdl/virtual_cpu_timer_queue.sv
sim/virtual_cpu_timer_queue_tb.sv
